FILE: rtl/core/fpsa_pkg.sv
// Shared types and constants of the free page stack allocator.
// Request, status and register codes, and the reset values of the limits.
package fpsa_pkg;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  localparam req_t REQ_ALLOC      = 2'd0;
  localparam req_t REQ_FREE_PAGE  = 2'd1;
  localparam req_t REQ_FREE_RANGE = 2'd2;

  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_BAD  = 2'd1;
  localparam status_t STATUS_OOM  = 2'd2;
  localparam status_t STATUS_FULL = 2'd3;

  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 1'd1;

  localparam logic [ADDR_W-1:0] LOW_LIMIT_RESET  = 32'h8020_0000;
  localparam logic [ADDR_W-1:0] HIGH_LIMIT_RESET = 32'h8800_0000;

endpackage

FILE: rtl/core/fpsa_ifs.sv
// Valid/ready channel interfaces of the free page stack allocator.
// Depends on fpsa_pkg for the payload types.
interface fpsa_req_if;
  logic                       valid;
  logic                       ready;
  fpsa_pkg::req_t             req_type;
  logic [fpsa_pkg::ADDR_W-1:0] free_address;
  logic [fpsa_pkg::ADDR_W-1:0] range_end_address;

  modport source (output valid, req_type, free_address, range_end_address, input ready);
  modport sink   (input valid, req_type, free_address, range_end_address, output ready);
endinterface

interface fpsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fpsa_pkg::ADDR_W-1:0]  alloc_address;
  fpsa_pkg::status_t           status;
  logic [fpsa_pkg::COUNT_W-1:0] free_count;

  modport source (output valid, alloc_address, status, free_count, input ready);
  modport sink   (input valid, alloc_address, status, free_count, output ready);
endinterface

FILE: rtl/core/free_page_stack_allocator.sv
// Free page allocator: a LIFO stack of page numbers in one synchronous RAM.
// Depends on fpsa_pkg and the channel interfaces in fpsa_ifs.sv.
//
//   channel  | direction | handshake        | beat
//   in_ch    | in        | valid / ready    | req_type, free_address, range_end_address
//   out_ch   | out       | valid / ready    | alloc_address, status, free_count
//   cfg_*    | in        | cfg_we only      | cfg_index, cfg_wdata
//
// Free-page and unused requests are answered straight from idle; allocate first
// reads the top entry from RAM (and answers directly when the stack is empty);
// free-range writes one RAM entry per page pushed, then answers.
// One request is worked on at a time; the next is taken once the result
// register is empty or its beat is taken in the same cycle.
// Reset is synchronous; it clears the count, state and result valid and loads the
// limits with their reset values. The RAM needs no clearing pass, since only entries below the count are ever read.
module free_page_stack_allocator #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fpsa_req_if.sink                          in_ch,
  fpsa_rsp_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpsa_pkg::ADDR_W-1:0]       cfg_wdata
);

  localparam int PB_W  = $clog2(PAGE_BYTES);
  localparam int PN_W  = fpsa_pkg::ADDR_W - PB_W;
  localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PAGES);
  localparam logic [32:0]      ROUND_UP = 33'(PAGE_BYTES - 1);
  localparam logic [33:0]      PB_STEP  = 34'(PAGE_BYTES);

  typedef enum logic [1:0] {ST_IDLE, ST_POP, ST_RANGE} state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [32:0]                  cur_r, cur_nxt;
  logic [fpsa_pkg::ADDR_W-1:0]  end_r, end_nxt;
  logic [fpsa_pkg::ADDR_W-1:0]  low_r, high_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [fpsa_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  fpsa_pkg::status_t            out_status_r, out_status_nxt;
  logic [fpsa_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [PN_W-1:0]              stack_mem [MAX_PAGES];
  logic [PN_W-1:0]              rd_data_r;
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_wa, mem_ra;
  logic [PN_W-1:0]              mem_wd;

  logic                         in_fire, full, empty, more;
  logic [CNT_W-1:0]             cnt_inc, cnt_dec;
  logic [32:0]                  in_addr, round_sum, range_start;
  logic [33:0]                  cur_step;

  function automatic logic page_bad(input logic [32:0] a,
                                    input logic [fpsa_pkg::ADDR_W-1:0] lo,
                                    input logic [fpsa_pkg::ADDR_W-1:0] hi);
    page_bad = (a[PB_W-1:0] != '0) || (a < {1'b0, lo}) || (a >= {1'b0, hi});
  endfunction

  assign in_ch.ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.alloc_address = out_addr_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.free_count    = out_count_r;

  assign full        = (count_r == CNT_MAX);
  assign empty       = (count_r == '0);
  assign cnt_inc     = count_r + 1'b1;
  assign cnt_dec     = count_r - 1'b1;
  assign in_addr     = {1'b0, in_ch.free_address};
  assign round_sum   = in_addr + ROUND_UP;
  assign range_start = {round_sum[32:PB_W], {PB_W{1'b0}}};
  assign cur_step    = {1'b0, cur_r} + PB_STEP;
  assign more        = (cur_step <= {2'b00, end_r});

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = count_r[AW-1:0];
    mem_wd         = in_ch.free_address[fpsa_pkg::ADDR_W-1:PB_W];
    mem_re         = 1'b0;
    mem_ra         = cnt_dec[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_addr_nxt   = '0;
          out_status_nxt = fpsa_pkg::STATUS_OK;
          out_count_nxt  = 16'(count_r);
          case (in_ch.req_type)
            fpsa_pkg::REQ_ALLOC: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fpsa_pkg::STATUS_OOM;
              end else begin
                // pop: read the top entry, answer when the data returns
                mem_re    = 1'b1;
                count_nxt = cnt_dec;
                state_nxt = ST_POP;
              end
            end
            fpsa_pkg::REQ_FREE_PAGE: begin
              out_valid_nxt = 1'b1;
              if (page_bad(in_addr, low_r, high_r)) begin
                out_status_nxt = fpsa_pkg::STATUS_BAD;
              end else if (full) begin
                out_status_nxt = fpsa_pkg::STATUS_FULL;
              end else begin
                mem_we        = 1'b1;
                count_nxt     = cnt_inc;
                out_count_nxt = 16'(cnt_inc);
              end
            end
            fpsa_pkg::REQ_FREE_RANGE: begin
              cur_nxt   = range_start;
              end_nxt   = in_ch.range_end_address;
              state_nxt = ST_RANGE;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = {rd_data_r, {PB_W{1'b0}}};
        out_status_nxt = fpsa_pkg::STATUS_OK;
        out_count_nxt  = 16'(count_r);
        state_nxt      = ST_IDLE;
      end
      ST_RANGE: begin
        out_count_nxt = 16'(count_r);
        if (!more) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fpsa_pkg::STATUS_OK;
          state_nxt      = ST_IDLE;
        end else if (page_bad(cur_r, low_r, high_r)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fpsa_pkg::STATUS_BAD;
          state_nxt      = ST_IDLE;
        end else if (full) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fpsa_pkg::STATUS_FULL;
          state_nxt      = ST_IDLE;
        end else begin
          // push one page and advance to the next
          mem_we    = 1'b1;
          mem_wd    = cur_r[fpsa_pkg::ADDR_W-1:PB_W];
          count_nxt = cnt_inc;
          cur_nxt   = cur_step[32:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Reads and writes never fall on the same edge: a pop is read only on taking an
  // allocate in idle, and no push is written while that request is taken.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      low_r       <= fpsa_pkg::LOW_LIMIT_RESET;
      high_r      <= fpsa_pkg::HIGH_LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == fpsa_pkg::CFG_LOW_LIMIT)) begin
        low_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == fpsa_pkg::CFG_HIGH_LIMIT)) begin
        high_r <= cfg_wdata;
      end
    end
    cur_r        <= cur_nxt;
    end_r        <= end_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
